/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MSET_ASSERT_NOW(lbl, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (res)) \
		else $error("timer port check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MSET_ASSERT_NEXT(lbl, cond, res) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error("timer port check failed");

`endif

/* hw/rtl/mset_pkg.sv */
`default_nettype none

package mset_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 8;
	localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int LATE_W      = 32;
	localparam int EXT_W       = (TIME_BITS > LATE_W) ? TIME_BITS : LATE_W;
	localparam logic [15:0] LIMIT_RESET = 16'd5;

	typedef logic [TIME_BITS-1:0] tstamp_t;

	typedef enum logic {
		REQ_REGISTER = 1'b0,
		REQ_TICK     = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		MODE_ONE_SHOT   = 2'd0,
		MODE_PERIODIC   = 2'd1,
		MODE_UNTIL_END  = 2'd2,
		MODE_WHILE_CONT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_REGISTERED = 2'd0,
		KIND_REFUSED    = 2'd1,
		KIND_FIRED      = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_FLUSH = 2'd2
	} state_t;

	typedef struct packed {
		req_t        req_type;
		mode_t       mode;
		logic [31:0] time_point;
		logic [23:0] period_ms;
		logic [7:0]  continue_mask;
	} req_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  slot;
		logic        late;
		logic [31:0] late_by_ms;
		logic        last;
	} res_word_t;

	typedef struct packed {
		mode_t       mode;
		tstamp_t     due;
		tstamp_t     end_t;
		logic [23:0] period;
	} slot_data_t;

	typedef struct packed {
		logic       valid;
		slot_data_t data;
	} slot_rec_t;

	typedef struct packed {
		req_t                  req_type;
		mode_t                 mode;
		tstamp_t               tp;
		logic [23:0]           period;
		logic                  cont;
		logic                  claimed;
		logic                  cap;
		tstamp_t               now;
		logic [15:0]           late_limit;
		logic [SLOT_IDX_W-1:0] idx;
	} scan_ctx_t;

	typedef struct packed {
		slot_rec_t rec;
		logic      fire;
		logic      claim;
		res_word_t word;
	} scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/mset_cell.sv */
`default_nettype none

module mset_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  mset_pkg::slot_rec_t   rec_in,
	output mset_pkg::slot_rec_t   rec_out
);
	import mset_pkg::*;

	logic       valid_q;
	slot_data_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= rec_in.data;
		end
	end

	assign rec_out.valid = valid_q;
	assign rec_out.data  = data_q;

endmodule

`default_nettype wire

/* hw/rtl/mset_eval.sv */
`default_nettype none

module mset_eval (
	input  mset_pkg::scan_ctx_t ctx,
	input  mset_pkg::slot_rec_t rec_in,
	output mset_pkg::scan_res_t res
);
	import mset_pkg::*;

	tstamp_t           el_due;
	tstamp_t           el_end;
	logic [EXT_W-1:0]  lat_ext;
	logic              sat;
	logic [LATE_W-1:0] late_by;

	always_comb begin
		el_due  = ctx.now - rec_in.data.due;
		// end time counts as passed once now reaches end + 1
		el_end  = ctx.now - rec_in.data.end_t - tstamp_t'(1);
		lat_ext = EXT_W'(el_due);
		sat     = |(lat_ext >> LATE_W);
		late_by = sat ? '1 : lat_ext[LATE_W-1:0];

		res       = '0;
		res.rec   = rec_in;
		res.fire  = 1'b0;
		res.claim = 1'b0;

		unique case (ctx.req_type)
			REQ_REGISTER: begin
				if (!rec_in.valid && !ctx.claimed) begin
					res.claim           = 1'b1;
					res.rec.valid       = 1'b1;
					res.rec.data.mode   = ctx.mode;
					res.rec.data.period = ctx.period;
					res.rec.data.end_t  = ctx.tp;
					res.rec.data.due    = (ctx.mode == MODE_ONE_SHOT) ? ctx.tp : ctx.now;
					res.word.kind       = KIND_REGISTERED;
					res.word.slot       = 3'(ctx.idx);
				end
			end
			REQ_TICK: begin
				if (rec_in.valid && !ctx.cap) begin
					if (rec_in.data.mode == MODE_UNTIL_END && !el_end[TIME_BITS-1]) begin
						res.rec.valid = 1'b0;
					end else if (!el_due[TIME_BITS-1]) begin
						if (rec_in.data.mode == MODE_WHILE_CONT && !ctx.cont) begin
							res.rec.valid = 1'b0;
						end else begin
							res.fire            = 1'b1;
							res.word.kind       = KIND_FIRED;
							res.word.slot       = 3'(ctx.idx);
							res.word.late_by_ms = late_by;
							res.word.late       = late_by > LATE_W'(ctx.late_limit);
							if (rec_in.data.mode == MODE_ONE_SHOT) begin
								res.rec.valid = 1'b0;
							end else begin
								res.rec.data.due = ctx.now + tstamp_t'(rec_in.data.period);
							end
						end
					end
				end
			end
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/multi_slot_event_timer_top.sv */
// Millisecond event timer with a table of slots held in a ring of cells.
// Request channel (req_valid/req_ready/req_word): a word either registers
// a timer (one-shot, periodic, periodic until an end time, periodic while
// its continue bit holds) or is a one millisecond tick.
// Result channel (res_valid/res_ready/res_word): a register word yields one
// result (registered with its slot, or refused); a tick yields one fired
// result per due slot in slot order, or none; last marks the final one.
// The slot records rotate once around the ring per word, one slot a cycle
// through the evaluator while the scan is not held; a flush state follows
// the scan, and req_ready returns only in idle, so no new word is taken
// until the last one is through.
// A result sits in the output register; while it is not taken and another
// fire must move out, the ring holds its position and the scan waits.
// cfg_wr_en writes the late limit. Reset clears all slots, the millisecond
// count and the output, and sets the late limit to 5.
`default_nettype none

module multi_slot_event_timer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mset_pkg::req_word_t req_word,
	output logic                res_valid,
	input  logic                res_ready,
	output mset_pkg::res_word_t res_word,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data
);
	import mset_pkg::*;

	localparam logic [SLOT_IDX_W-1:0] IDX_LAST = SLOT_IDX_W'(NUM_SLOTS - 1);

	state_t                state_q, state_d;
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;
	logic                  claimed_q;
	tstamp_t               now_q;
	logic [15:0]           limit_q;
	req_word_t             item_q;
	logic                  pend_valid_q;
	res_word_t             pend_q;
	logic                  out_valid_q;
	res_word_t             out_q;

	slot_rec_t             ring [NUM_SLOTS];
	scan_ctx_t             ctx;
	scan_res_t             ev;
	logic [2:0]            cont_sel;
	logic                  accept;
	logic                  advance;
	logic                  push;
	logic                  flush;
	logic                  out_free;
	res_word_t             out_d;
	res_word_t             refused_word;

	assign accept   = req_valid && req_ready;
	assign out_free = !out_valid_q || res_ready;
	assign cont_sel = 3'(idx_q);

	always_comb begin
		ctx            = '0;
		ctx.req_type   = item_q.req_type;
		ctx.mode       = item_q.mode;
		ctx.tp         = tstamp_t'(item_q.time_point);
		ctx.period     = item_q.period_ms;
		ctx.cont       = item_q.continue_mask[cont_sel];
		ctx.claimed    = claimed_q;
		ctx.cap        = (fire_cnt_q == FIRE_CNT_W'(MAX_RESULTS));
		ctx.now        = now_q;
		ctx.late_limit = limit_q;
		ctx.idx        = idx_q;
	end

	mset_eval u_eval (
		.ctx    (ctx),
		.rec_in (ring[0]),
		.res    (ev)
	);

	// cell j takes from cell j+1; the evaluated head record re-enters at the tail
	for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_ring
		if (j == NUM_SLOTS - 1) begin : g_tail
			mset_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.rec_in   (ev.rec),
				.rec_out  (ring[j])
			);
		end else begin : g_body
			mset_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (advance),
				.rec_in   (ring[j+1]),
				.rec_out  (ring[j])
			);
		end
	end

	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		flush   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// hold the ring while a second fire has nowhere to go
				advance = !(ev.fire && pend_valid_q) || out_free;
				if (advance && idx_q == IDX_LAST) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		push       = advance && ev.fire && pend_valid_q;
		out_d      = pend_q;
		out_d.last = flush;

		refused_word      = '0;
		refused_word.kind = KIND_REFUSED;
	end

	assign req_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			fire_cnt_q   <= '0;
			claimed_q    <= 1'b0;
			now_q        <= '0;
			limit_q      <= LIMIT_RESET;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				idx_q        <= '0;
				fire_cnt_q   <= '0;
				claimed_q    <= 1'b0;
				pend_valid_q <= (req_word.req_type == REQ_REGISTER);
				if (req_word.req_type == REQ_TICK) begin
					now_q <= now_q + tstamp_t'(1);
				end
			end else if (advance) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + SLOT_IDX_W'(1);
				if (ev.fire) begin
					fire_cnt_q   <= fire_cnt_q + FIRE_CNT_W'(1);
					pend_valid_q <= 1'b1;
				end
				if (ev.claim) begin
					claimed_q <= 1'b1;
				end
			end else if (flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push || flush) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_word;
			pend_q <= refused_word;
		end else if (advance && (ev.fire || ev.claim)) begin
			pend_q <= ev.word;
		end
		if (push || flush) begin
			out_q <= out_d;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/mset_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module mset_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input mset_pkg::req_word_t req_word,
	input logic                res_valid,
	input logic                res_ready,
	input mset_pkg::res_word_t res_word
);
	import mset_pkg::*;

	logic tick_word;
	assign tick_word = (req_word.req_type == REQ_TICK);

	// a stalled result stays put
	`MSET_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))

	// one word at a time: busy right after an accept, whatever the word
	`MSET_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready && (tick_word || !tick_word), !req_ready)

	// register results come alone and carry no lateness
	`MSET_ASSERT_NOW(a_reg_result_shape, res_valid && res_word.kind != KIND_FIRED, res_word.last && !res_word.late && res_word.late_by_ms == 32'd0)

	// a refusal always names slot zero
	`MSET_ASSERT_NOW(a_refused_slot, res_valid && res_word.kind == KIND_REFUSED, res_word.slot == 3'd0)

	// a late flag needs nonzero lateness
	`MSET_ASSERT_NOW(a_late_nonzero, res_valid && res_word.late, res_word.late_by_ms != 32'd0)

endmodule

bind multi_slot_event_timer_top mset_checker u_mset_checker (.*);

`default_nettype wire
